[rtl/mtgl_pkg.sv]
// ----------------------------------------------------------------------------
// mtgl_pkg
// Shared types, constants and helper functions for the markup text glyph layout block.
// ----------------------------------------------------------------------------
package mtgl_pkg;

  typedef struct packed {
    logic       func;
    logic       string_start;
    logic [7:0] text_byte;
    logic [1:0] bytes_after;
    logic [7:0] glyph_slot;
    logic [5:0] glyph_width_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic [5:0]  quad_width;
    logic [15:0] tex_x;
    logic [15:0] tex_y;
    logic [5:0]  tex_width;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        bold_on;
    logic        italic_on;
    logic        rendered;
  } out_item_t;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [2:0] REG_FIRST_CODE    = 3'd0;
  localparam logic [2:0] REG_CELLS_PER_ROW = 3'd1;
  localparam logic [2:0] REG_CELL_WIDTH    = 3'd2;
  localparam logic [2:0] REG_CELL_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_TEXT_SPACING  = 3'd4;
  localparam logic [2:0] REG_WRAP_WIDTH    = 3'd5;
  localparam logic [2:0] REG_PARSE_CODES   = 3'd6;
  localparam logic [2:0] REG_BASE_COLOR    = 3'd7;

  typedef enum logic [2:0] {
    ESC_NONE  = 3'd0,
    ESC_HASH  = 3'd1,
    ESC_RED   = 3'd2,
    ESC_GREEN = 3'd3,
    ESC_BLUE  = 3'd4
  } esc_t;

  localparam logic [7:0] CHR_ESCAPE  = 8'd3;
  localparam logic [7:0] CHR_NEWLINE = 8'd10;

  function automatic logic [23:0] palette(input logic [2:0] i);
    logic [23:0] c;
    unique case (i)
      3'd0: c = 24'hFFFFFF;
      3'd1: c = 24'hFF6060;
      3'd2: c = 24'hFFFF60;
      3'd3: c = 24'h60FF60;
      3'd4: c = 24'h60FFFF;
      3'd5: c = 24'h6060FF;
      3'd6: c = 24'hFF60FF;
      default: c = 24'hA0A0A0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_level(input logic [7:0] c);
    logic [3:0] d;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
    else d = 4'd0;
    return {d, 4'hF};
  endfunction

endpackage

[rtl/markup_text_glyph_layout_top.sv]
// ----------------------------------------------------------------------------
// markup_text_glyph_layout_top
// Markup parser and glyph quad layout, one text byte per transaction.
// ----------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   in       input      in_valid/in_ready   mtgl_pkg::in_item_t
//   out      output     out_valid/out_ready mtgl_pkg::out_item_t
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// A load passes through S_READ and returns to idle; a text byte passes
// through S_READ, the quotient steps of the cell division by cells_per_row
// (one shared restoring subtract/compare, 8 steps) and S_DONE, then the
// result waits in the output register. The input is not ready while an
// item is in work or a result is unsent. Reset clears registers and sweeps
// every slot of the width table, during which no item is accepted.
// ----------------------------------------------------------------------------
module markup_text_glyph_layout_top #(
  parameter int GLYPH_SLOTS = 256,
  parameter int POS_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mtgl_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mtgl_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [mtgl_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mtgl_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import mtgl_pkg::*;

  localparam int SB = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_DIV   = 6'b001000,
    S_DONE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic [7:0]  first_code;
  logic [8:0]  cells_per_row;
  logic [5:0]  cell_width, cell_height;
  logic [7:0]  text_spacing;
  logic [15:0] wrap_width;
  logic        parse_codes;
  logic [23:0] base_color;

  esc_t        escape_mode;
  logic [23:0] cur_color;
  logic        bold_flag, italic_flag;
  logic [POS_BITS-1:0] pen_pos_x, pen_pos_y;
  logic [15:0] last_tex_x, last_tex_y;
  logic [5:0]  last_tex_width;

  logic [5:0]  width_mem [GLYPH_SLOTS];
  logic [5:0]  mem_rd;
  logic [SB:0] clr_cnt;

  in_item_t    item;
  logic [2:0]  div_cnt;
  logic [7:0]  quo;
  logic [8:0]  rem_r;
  logic [7:0]  idx;
  out_item_t   result;

  // Restoring division step shared across cycles
  logic [8:0]  cpr;
  logic [9:0]  trial;
  assign cpr = (cells_per_row == 9'd0) ? 9'd1 : cells_per_row;
  assign trial = {rem_r, idx[3'd7 - div_cnt]};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_code <= 8'd32; cells_per_row <= 9'd16; cell_width <= 6'd8;
      cell_height <= 6'd8; text_spacing <= 8'd17; wrap_width <= '0;
      parse_codes <= 1'b1; base_color <= 24'hFFFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_CODE:    first_code <= cfg_data[7:0];
        REG_CELLS_PER_ROW: cells_per_row <= cfg_data[8:0];
        REG_CELL_WIDTH:    cell_width <= cfg_data[5:0];
        REG_CELL_HEIGHT:   cell_height <= cfg_data[5:0];
        REG_TEXT_SPACING:  text_spacing <= cfg_data[7:0];
        REG_WRAP_WIDTH:    wrap_width <= cfg_data[15:0];
        REG_PARSE_CODES:   parse_codes <= cfg_data[0];
        REG_BASE_COLOR:    base_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Width table: clear sweep, load writes, registered read
  logic in_range_load, in_range_read;
  assign in_range_load = 32'(item.glyph_slot) < GLYPH_SLOTS;
  assign in_range_read = 32'(idx) < GLYPH_SLOTS;

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) width_mem[clr_cnt[SB-1:0]] <= '0;
    else if (state == S_READ && item.func && in_range_load)
      width_mem[item.glyph_slot[SB-1:0]] <= item.glyph_width_in;
    mem_rd <= width_mem[idx[SB-1:0]];
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = result;

  // Text byte decode, evaluated in S_DONE
  logic [7:0]  chr;
  logic        rend, nl;
  logic [5:0]  w;
  logic [6:0]  adv;
  esc_t        esc_n;
  logic [23:0] col_n;
  logic        ital_n, bold_n;
  logic [POS_BITS:0] sum_x, sum_y;
  logic [POS_BITS-1:0] px_q, py_q;
  logic [16:0] xw;

  always_comb begin
    chr = item.text_byte;
    rend = (escape_mode == ESC_NONE);
    nl = 1'b0;
    w = '0;
    adv = '0;
    esc_n = escape_mode;
    col_n = cur_color;
    ital_n = italic_flag;
    bold_n = bold_flag;
    if (parse_codes && chr == CHR_ESCAPE && escape_mode != ESC_HASH
        && item.bytes_after != 2'd0) begin
      esc_n = ESC_HASH;
      rend = 1'b0;
    end else if (escape_mode == ESC_HASH && chr != CHR_ESCAPE) begin
      esc_n = ESC_NONE;
      if (chr == "r") col_n = base_color;
      else if (chr == "R") begin
        ital_n = 1'b0; col_n = base_color;
      end else if (chr == "*" && item.bytes_after == 2'd3) esc_n = ESC_RED;
      else if (chr >= "a" && chr <= "h") col_n = palette(3'(chr - "a"));
      else if (chr >= "A" && chr <= "H")
        col_n = (palette(3'(chr - "A")) >> 1) & 24'h7F7F7F;
      else if (chr == "i") ital_n = ~italic_flag;
      else if (chr == "j") bold_n = ~bold_flag;
    end else if (escape_mode == ESC_RED) begin
      col_n[23:16] = hex_level(chr); esc_n = ESC_GREEN;
    end else if (escape_mode == ESC_GREEN) begin
      col_n[15:8] = hex_level(chr); esc_n = ESC_BLUE;
    end else if (escape_mode == ESC_BLUE) begin
      col_n[7:0] = hex_level(chr); esc_n = ESC_NONE;
    end else if (escape_mode == ESC_NONE && chr == CHR_NEWLINE) begin
      nl = 1'b1;
    end else if (escape_mode == ESC_NONE) begin
      w = (chr >= first_code && in_range_read) ? mem_rd : 6'd0;
      adv = 7'(w) + 7'(text_spacing[3:0]);
      if (wrap_width != 16'd0 &&
          (32'(pen_pos_x) + 32'(adv)) > 32'(wrap_width)) nl = 1'b1;
    end
    sum_y = (POS_BITS+1)'(pen_pos_y) + (POS_BITS+1)'(cell_height)
            + (POS_BITS+1)'(text_spacing[7:4]);
    py_q = nl ? (sum_y[POS_BITS] ? POS_MAX : sum_y[POS_BITS-1:0]) : pen_pos_y;
    px_q = nl ? '0 : pen_pos_x;
    sum_x = (POS_BITS+1)'(px_q) + (POS_BITS+1)'(adv);
    xw = 17'(rem_r[7:0]) * 17'(7'(cell_width) + 7'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      escape_mode <= ESC_NONE;
      cur_color <= 24'hFFFFFF;
      bold_flag <= 1'b0; italic_flag <= 1'b0;
      pen_pos_x <= '0; pen_pos_y <= '0;
      last_tex_x <= '0; last_tex_y <= '0; last_tex_width <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SB+1)'(GLYPH_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          item <= in_data;
          idx <= in_data.text_byte - first_code;
          state <= S_READ;
          if (!in_data.func && in_data.string_start) begin
            escape_mode <= ESC_NONE; cur_color <= base_color;
            bold_flag <= 1'b0; italic_flag <= 1'b0;
            pen_pos_x <= '0; pen_pos_y <= '0;
            last_tex_x <= '0; last_tex_y <= '0; last_tex_width <= '0;
          end
        end
        S_READ: begin
          rem_r <= '0; quo <= '0; div_cnt <= '0;
          state <= item.func ? S_IDLE : S_DIV;
        end
        S_DIV: begin
          if (trial >= 10'(cpr)) begin
            rem_r <= 9'(trial - 10'(cpr)); quo <= {quo[6:0], 1'b1};
          end else begin
            rem_r <= trial[8:0]; quo <= {quo[6:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 3'd7) state <= S_DONE;
        end
        S_DONE: begin
          escape_mode <= esc_n; cur_color <= col_n;
          italic_flag <= ital_n; bold_flag <= bold_n;
          pen_pos_y <= py_q;
          pen_pos_x <= sum_x[POS_BITS] ? POS_MAX : sum_x[POS_BITS-1:0];
          result.pen_x <= 16'(px_q);
          result.pen_y <= 16'(py_q);
          result.quad_width <= w;
          result.red <= col_n[23:16];
          result.green <= col_n[15:8];
          result.blue <= col_n[7:0];
          result.bold_on <= bold_n;
          result.italic_on <= ital_n;
          result.rendered <= rend;
          result.tex_width <= last_tex_width;
          result.tex_x <= last_tex_x;
          result.tex_y <= last_tex_y;
          if (escape_mode == ESC_NONE && !(parse_codes && chr == CHR_ESCAPE
              && item.bytes_after != 2'd0) && chr != CHR_NEWLINE) begin
            last_tex_x <= xw[15:0];
            last_tex_y <= 16'(17'(quo) * 17'(7'(cell_height) + 7'd1));
            last_tex_width <= w;
            result.tex_x <= xw[15:0];
            result.tex_y <= 16'(17'(quo) * 17'(7'(cell_height) + 7'd1));
            result.tex_width <= w;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE)) else $error("spurious result");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> $past(state == S_DIV)) else $error("division cut short");

endmodule

[test/markup_text_glyph_layout_top_test.sv]
// ----------------------------------------------------------------------------
// markup_text_glyph_layout_top_test
// Drives text bytes, width loads and register writes into the glyph layout
// block and compares every quad against a behavioral predictor of the parser,
// pen, texture cell and color logic.
// ----------------------------------------------------------------------------
module markup_text_glyph_layout_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mtgl_pkg::*;

  localparam int SLOTS = 256;
  localparam int POS_MAX = 65535;
  localparam int CYCLE_LIMIT = 2000000;

  // behavioral predictor plus queue of expected quads
  class quad_scoreboard;
    logic [7:0] first_code;
    logic [8:0] cells_per_row;
    logic [5:0] cell_width, cell_height;
    logic [7:0] text_spacing;
    logic [15:0] wrap_width;
    logic parse_codes;
    logic [23:0] base_color;
    esc_t esc;
    logic [23:0] color;
    logic bold, italic;
    int pen_x, pen_y;
    logic [15:0] tx, ty;
    logic [5:0] tw;
    logic [5:0] widths[SLOTS];
    out_item_t pending[$];
    int errors;

    function new();
      errors = 0;
      first_code = 8'd32; cells_per_row = 9'd16; cell_width = 6'd8; cell_height = 6'd8;
      text_spacing = 8'd17; wrap_width = 16'd0; parse_codes = 1'b1;
      base_color = 24'hFFFFFF;
      foreach (widths[i]) widths[i] = '0;
      restart();
    endfunction

    function void restart();
      esc = ESC_NONE; color = base_color; bold = 0; italic = 0;
      pen_x = 0; pen_y = 0; tx = '0; ty = '0; tw = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] v);
      case (idx)
        REG_FIRST_CODE: first_code = v[7:0];
        REG_CELLS_PER_ROW: cells_per_row = v[8:0];
        REG_CELL_WIDTH: cell_width = v[5:0];
        REG_CELL_HEIGHT: cell_height = v[5:0];
        REG_TEXT_SPACING: text_spacing = v[7:0];
        REG_WRAP_WIDTH: wrap_width = v[15:0];
        REG_PARSE_CODES: parse_codes = v[0];
        default: base_color = v;
      endcase
    endfunction

    function logic [7:0] digit_level(logic [7:0] c);
      int d;
      d = 0;
      if (c >= "0" && c <= "9") d = c - "0";
      else if (c >= "a" && c <= "f") d = c - "a" + 10;
      else if (c >= "A" && c <= "F") d = c - "A" + 10;
      return 8'(d * 16 + 15);
    endfunction

    function logic [23:0] tint(int i);
      logic [23:0] t[8] = '{24'hFFFFFF, 24'hFF6060, 24'hFFFF60, 24'h60FF60,
                            24'h60FFFF, 24'h6060FF, 24'hFF60FF, 24'hA0A0A0};
      return t[i];
    endfunction

    function void note_input(in_item_t it);
      logic [7:0] c;
      logic rend, brk;
      int adv, idx, cpr, w;
      out_item_t q;
      adv = 0; w = 0; brk = 0;
      if (it.func) begin
        widths[it.glyph_slot] = it.glyph_width_in;
        return;
      end
      if (it.string_start) restart();
      c = it.text_byte;
      rend = (esc == ESC_NONE);
      if (parse_codes && c == CHR_ESCAPE && esc != ESC_HASH && it.bytes_after >= 1) begin
        esc = ESC_HASH; rend = 0;
      end else if (esc == ESC_HASH && c != CHR_ESCAPE) begin
        esc = ESC_NONE;
        if (c == "r") color = base_color;
        else if (c == "R") begin
          italic = 0; color = base_color;
        end else if (c == "*" && it.bytes_after == 3) esc = ESC_RED;
        else if (c >= "a" && c <= "h") color = tint(c - "a");
        else if (c >= "A" && c <= "H") color = (tint(c - "A") >> 1) & 24'h7F7F7F;
        else if (c == "i") italic = ~italic;
        else if (c == "j") bold = ~bold;
      end else if (esc == ESC_RED) begin
        color[23:16] = digit_level(c); esc = ESC_GREEN;
      end else if (esc == ESC_GREEN) begin
        color[15:8] = digit_level(c); esc = ESC_BLUE;
      end else if (esc == ESC_BLUE) begin
        color[7:0] = digit_level(c); esc = ESC_NONE;
      end else if (esc == ESC_NONE && c == CHR_NEWLINE) begin
        brk = 1;
      end else if (esc == ESC_NONE) begin
        idx = (c - first_code) & 255;
        cpr = (cells_per_row == 0) ? 1 : cells_per_row;
        if (c >= first_code) w = widths[idx];
        tx = 16'((idx % cpr) * (cell_width + 1));
        ty = 16'((idx / cpr) * (cell_height + 1));
        tw = 6'(w);
        adv = w + text_spacing[3:0];
        if (wrap_width > 0 && pen_x + adv > wrap_width) brk = 1;
      end
      if (brk) begin
        pen_x = 0;
        pen_y = pen_y + cell_height + text_spacing[7:4];
        if (pen_y > POS_MAX) pen_y = POS_MAX;
      end
      q = '{pen_x: 16'(pen_x), pen_y: 16'(pen_y), quad_width: 6'(w), tex_x: tx,
            tex_y: ty, tex_width: tw, red: color[23:16], green: color[15:8],
            blue: color[7:0], bold_on: bold, italic_on: italic, rendered: rend};
      pending = {pending, q};
      pen_x = pen_x + adv;
      if (pen_x > POS_MAX) pen_x = POS_MAX;
    endfunction

    function void check_quad(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected quad %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pen_x !== want.pen_x || got.pen_y !== want.pen_y ||
          got.quad_width !== want.quad_width || got.tex_x !== want.tex_x ||
          got.tex_y !== want.tex_y || got.tex_width !== want.tex_width ||
          got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.bold_on !== want.bold_on || got.italic_on !== want.italic_on ||
          got.rendered !== want.rendered) begin
        $display("%0t: quad mismatch expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, cfg_we = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  int send_idle = 0, recv_idle = 0, hold_off = 0, cycles = 0;
  quad_scoreboard sb = new();

  markup_text_glyph_layout_top u_top (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_quad(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // valid stays up after an accepted transaction until the next one or an idle
  task automatic send(in_item_t it);
    cfg_we <= 0;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic text(logic [7:0] c, logic first = 0, logic [1:0] after = 3);
    in_item_t it;
    it = '0;
    it.string_start = first; it.text_byte = c; it.bytes_after = after;
    it.glyph_slot = 8'($urandom); it.glyph_width_in = 6'($urandom);
    send(it);
  endtask

  task automatic load(logic [7:0] slot, logic [5:0] w);
    in_item_t it;
    it = '0;
    it.func = 1; it.glyph_slot = slot; it.glyph_width_in = w;
    it.text_byte = 8'($urandom); it.bytes_after = 2'($urandom);
    it.string_start = 1'($urandom);
    send(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] v);
    in_valid <= 0;
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // a random string: mostly glyphs, some markup and newlines
  task automatic random_string(int len);
    int r;
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 8) c = CHR_ESCAPE;
      else if (r < 12) c = CHR_NEWLINE;
      else if (r < 20) c = "0" + 8'($urandom_range(54));
      else if (r < 28) c = "a" + 8'($urandom_range(9));
      else if (r < 32) c = "*";
      else if (r < 40) c = 8'($urandom);
      else c = 8'($urandom_range(32, 126));
      text(c, i == 0, (len - 1 - i) > 3 ? 2'd3 : 2'(len - 1 - i));
      if ($urandom_range(99) < 4) load(8'($urandom), 6'($urandom));
    end
  endtask

  task automatic random_config();
    write_reg(REG_FIRST_CODE, $urandom_range(3) == 0 ? 24'($urandom_range(255)) : 24'd32);
    write_reg(REG_CELLS_PER_ROW, 24'($urandom_range(3) == 0 ? $urandom_range(511)
                                                           : $urandom_range(1, 20)));
    write_reg(REG_CELL_WIDTH, 24'($urandom_range(63)));
    write_reg(REG_CELL_HEIGHT, 24'($urandom_range(63)));
    write_reg(REG_TEXT_SPACING, 24'($urandom_range(255)));
    write_reg(REG_WRAP_WIDTH, $urandom_range(2) == 0 ? 24'd0 : 24'($urandom_range(300)));
    write_reg(REG_PARSE_CODES, 24'($urandom_range(3) != 0));
    write_reg(REG_BASE_COLOR, 24'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed: extremes, markup letters, special cases
    for (int s = 0; s < 4; s++) load(8'(32 + s), 6'(s * 21));
    load(8'hFF, 6'h3F);
    text("A", 1); text(" "); text(8'hFF); text(8'h00); text(CHR_NEWLINE);
    text(CHR_ESCAPE); text("b"); text(CHR_ESCAPE); text("C"); text(CHR_ESCAPE);
    text("i"); text(CHR_ESCAPE); text("j"); text(CHR_ESCAPE); text("R");
    text(CHR_ESCAPE); text(CHR_ESCAPE); text("z");
    text(CHR_ESCAPE); text("*"); text("f"); text("A"); text("q");
    text(CHR_ESCAPE, 0, 0); text(CHR_ESCAPE, 0, 1); text("*", 0, 2); text("r");
    drain();
    write_reg(REG_FIRST_CODE, 24'd255); write_reg(REG_CELLS_PER_ROW, 24'd0);
    write_reg(REG_CELL_WIDTH, 24'd63); write_reg(REG_CELL_HEIGHT, 24'd63);
    write_reg(REG_TEXT_SPACING, 24'hFF); write_reg(REG_WRAP_WIDTH, 24'hFFFF);
    write_reg(REG_PARSE_CODES, 24'd0); write_reg(REG_BASE_COLOR, 24'h000000);
    text(8'hFF, 1); text(8'h00); text(CHR_ESCAPE); text("a");
    for (int i = 0; i < 950; i++) text(CHR_NEWLINE, 0, 3); // saturate pen_y
    drain();
    write_reg(REG_CELLS_PER_ROW, 24'd256); write_reg(REG_WRAP_WIDTH, 24'd1);
    write_reg(REG_PARSE_CODES, 24'd1); write_reg(REG_FIRST_CODE, 24'd0);
    text(8'hFF, 1); text(8'h20); text(8'h21);
    drain();
    for (int i = 0; i < 64; i++) load(8'($urandom), 6'($urandom));
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 9 : (ph == 1) ? 76 : 0;
      recv_idle = (ph == 0) ? 76 : (ph == 1) ? 9 : 0;
      for (int k = 0; k < 6; k++) begin
        random_config();
        if (k == 2) hold_off = 300;
        random_string($urandom_range(4, 30));
        drain();
      end
    end
    drain();
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
